>>> hdl/vma_pkg.sv
// Shared constants, types and helpers for the voltage moving-average block.
`default_nettype none
package vma_pkg;

	localparam int WINDOW_SAMPLES = 8;
	localparam int WINDOW_SHIFT   = 3;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_SAMPLES);
	localparam int PTR_W    = $clog2(WINDOW_SAMPLES);
	localparam int CNT_W    = $clog2(WINDOW_SAMPLES + 1);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_SAMPLES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_SAMPLES);
	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'({SAMPLE_W{1'b1}});

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		sample_t filtered_mv;
		logic    window_full;
	} result_t;

	// Scale the window sum down to one sample and clamp it to the sample range.
	function automatic sample_t scale_sum(input sum_t sum);
		sum_t shifted;
		shifted = sum >> WINDOW_SHIFT;
		if (shifted > SAT_LIMIT) begin
			scale_sum = {SAMPLE_W{1'b1}};
		end else begin
			scale_sum = shifted[SAMPLE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> hdl/vma_in_stage.sv
// Input register stage that holds one accepted sample until the window takes it.
`default_nettype none
module vma_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              advance,
	input  wire vma_pkg::sample_t  sample,
	output logic                   valid_s1,
	output vma_pkg::sample_t       sample_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= sample;
		end
	end

endmodule
`default_nettype wire

>>> hdl/vma_window.sv
// Sample window with running sum; produces the result for the staged sample.
`default_nettype none
module vma_window (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire vma_pkg::sample_t sample_s1,
	output vma_pkg::result_t      result
);

	vma_pkg::sample_t store_q [vma_pkg::WINDOW_SAMPLES];
	vma_pkg::sum_t    sum_q;
	vma_pkg::ptr_t    ptr_q;
	vma_pkg::cnt_t    fill_q;

	logic             full;
	vma_pkg::sample_t oldest;
	vma_pkg::sum_t    sum_next;

	assign full = (fill_q == vma_pkg::FULL_CNT);

	// Entries are only subtracted once the window is full, so the store needs no reset.
	assign oldest   = full ? store_q[ptr_q] : '0;
	assign sum_next = sum_q - vma_pkg::SUM_W'(oldest) + vma_pkg::SUM_W'(sample_s1);

	always_comb begin
		result.window_full = full;
		result.filtered_mv = full ? vma_pkg::scale_sum(sum_next) : sample_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (step) begin
			sum_q <= sum_next;
			ptr_q <= (ptr_q == vma_pkg::LAST_SLOT) ? '0 : ptr_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			store_q[ptr_q] <= sample_s1;
		end
	end

endmodule
`default_nettype wire

>>> hdl/vma_out_stage.sv
// Result register that holds a finished item until the downstream side takes it.
`default_nettype none
module vma_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             out_stall,
	input  wire vma_pkg::result_t result,
	output logic                  out_valid,
	output vma_pkg::sample_t      filtered_mv,
	output logic                  window_full
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			filtered_mv <= result.filtered_mv;
			window_full <= result.window_full;
		end
	end

endmodule
`default_nettype wire

>>> hdl/voltage_moving_average.sv
// An accepted sample moves from the input register through the window into the result register.
// One item per cycle while out_stall is low; the running sum updates each sample in one pass.
// A result waiting under out_stall lets the input register take one more item, then stalls it.
// Reset (arst_n low, asynchronous) empties both stages and clears the sum, fill count and
// write slot; the window starts in warm-up, passing the first samples through unfiltered.
`default_nettype none
module voltage_moving_average (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire vma_pkg::sample_t sample_mv,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output vma_pkg::sample_t      filtered_mv,
	output logic                  window_full
);

	logic             valid_s1;
	vma_pkg::sample_t sample_s1;
	vma_pkg::result_t result;
	logic             out_free;
	logic             move_s1;
	logic             in_accept;

	assign out_free  = !out_valid || !out_stall;
	assign move_s1   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	vma_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.advance   (move_s1),
		.sample    (sample_mv),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	vma_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (move_s1),
		.sample_s1 (sample_s1),
		.result    (result)
	);

	vma_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (move_s1),
		.out_stall   (out_stall),
		.result      (result),
		.out_valid   (out_valid),
		.filtered_mv (filtered_mv),
		.window_full (window_full)
	);

endmodule
`default_nettype wire

>>> hdl/vma_checker.sv
// Port-level checks for the voltage moving-average block and their bind to the top level.
`default_nettype none
module vma_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire vma_pkg::sample_t sample_mv,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire vma_pkg::sample_t filtered_mv,
	input wire logic             window_full
);

	// A stalled input item stays offered with the same sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_mv))
		else $error("stalled input item changed");

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(filtered_mv) && $stable(window_full))
		else $error("stalled result changed");

	// Input backpressure only arises from a blocked output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// Once averaging has started it never falls back to warm-up.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_full |=> !out_valid || window_full)
		else $error("window_full dropped after averaging began");

endmodule

bind voltage_moving_average vma_checker u_vma_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.sample_mv   (sample_mv),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.filtered_mv (filtered_mv),
	.window_full (window_full)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the voltage moving-average filter with a running-sum predictor.
`timescale 1ns / 100ps
module testbench;

	localparam int SEND_IDLE_LIGHT = 14;
	localparam int RECV_STALL_HEAVY = 87;
	localparam int SEND_IDLE_HEAVY = 87;
	localparam int RECV_STALL_LIGHT = 14;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam longint unsigned LEVEL_MAX = (64'd1 << vma_pkg::SAMPLE_W) - 1;

	typedef struct packed {
		vma_pkg::sample_t level;
		logic             averaged;
	} reading_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	vma_pkg::sample_t sample_mv = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	vma_pkg::sample_t filtered_mv;
	logic             window_full;

	vma_pkg::sample_t pending_samples[$];
	reading_t         expected_readings[$];
	int               send_idle_pct = SEND_IDLE_LIGHT;
	int               recv_stall_pct = RECV_STALL_HEAVY;
	bit               sender_hold = 1'b0;
	int               error_count = 0;

	// Predictor state: a copy of the window, its running sum and the eviction slot.
	vma_pkg::sample_t window_copy[vma_pkg::WINDOW_SAMPLES];
	int unsigned      samples_held = 0;
	longint unsigned  running_sum = 0;
	int unsigned      evict_slot = 0;

	voltage_moving_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_mv(sample_mv),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_mv(filtered_mv),
		.window_full(window_full)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic reading_t filter_sample(input vma_pkg::sample_t s);
		reading_t        r;
		longint unsigned scaled;
		if (samples_held < vma_pkg::WINDOW_SAMPLES) begin
			window_copy[samples_held] = s;
			running_sum += s;
			samples_held++;
			r.level = s;
			r.averaged = 1'b0;
		end else begin
			running_sum = running_sum - window_copy[evict_slot] + s;
			window_copy[evict_slot] = s;
			evict_slot = (evict_slot == vma_pkg::WINDOW_SAMPLES - 1) ? 0 : evict_slot + 1;
			scaled = running_sum >> vma_pkg::WINDOW_SHIFT;
			r.level = (scaled > LEVEL_MAX) ? vma_pkg::sample_t'(LEVEL_MAX) :
			          vma_pkg::sample_t'(scaled);
			r.averaged = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	function automatic vma_pkg::sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return vma_pkg::sample_t'($urandom);
			default: return vma_pkg::sample_t'($urandom_range(3000, 4200));
		endcase
	endfunction

	// Mostly battery-like levels, with runs of one extreme long enough to flush the window.
	task automatic queue_samples(input int count);
		int               left;
		int               run;
		vma_pkg::sample_t s;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 7) == 0) begin
				run = $urandom_range(vma_pkg::WINDOW_SAMPLES, vma_pkg::WINDOW_SAMPLES + 4);
				s = $urandom_range(0, 1) ? '1 : '0;
				while (run > 0 && left > 0) begin
					pending_samples.push_back(s);
					run--;
					left--;
				end
			end else begin
				pending_samples.push_back(pick_sample());
				left--;
			end
		end
	endtask

	task automatic drain_sender();
		while (pending_samples.size() != 0 || in_valid) @(posedge clk);
	endtask

	// Hold new items back until every result in flight has been delivered.
	task automatic hold_until_quiet();
		sender_hold = 1'b1;
		while (in_valid || expected_readings.size() != 0) @(posedge clk);
		sender_hold = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample_mv <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_readings.push_back(filter_sample(sample_mv));
			end
			if (!in_valid || !in_stall) begin
				if (!sender_hold && pending_samples.size() != 0 &&
				    $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample_mv <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected result, filtered_mv", filtered_mv, 0);
				end else begin
					want = expected_readings.pop_front();
					if (filtered_mv !== want.level) begin
						report_mismatch("filtered_mv", filtered_mv, want.level);
					end
					if (window_full !== want.averaged) begin
						report_mismatch("window_full", window_full, want.averaged);
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		// Warm-up with field extremes and alternating bit patterns; the eighth completes the window.
		pending_samples.push_back('0);
		pending_samples.push_back('1);
		pending_samples.push_back(vma_pkg::sample_t'(1));
		pending_samples.push_back(vma_pkg::sample_t'(16'h8000));
		pending_samples.push_back(vma_pkg::sample_t'(16'h7FFF));
		pending_samples.push_back(vma_pkg::sample_t'(16'hAAAA));
		pending_samples.push_back(vma_pkg::sample_t'(16'h5555));
		pending_samples.push_back(vma_pkg::sample_t'(3700));
		// A full window of maximum samples drives the sum to its top, then all zeros drain it.
		repeat (vma_pkg::WINDOW_SAMPLES) pending_samples.push_back('1);
		repeat (vma_pkg::WINDOW_SAMPLES) pending_samples.push_back('0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		drain_sender();
		hold_until_quiet();
		queue_samples(ITEMS_PER_PHASE);
		drain_sender();
		hold_until_quiet();

		send_idle_pct = SEND_IDLE_HEAVY;
		recv_stall_pct = RECV_STALL_LIGHT;
		queue_samples(ITEMS_PER_PHASE);
		drain_sender();
		hold_until_quiet();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_samples(ITEMS_PER_PHASE);
		drain_sender();
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
